// ===== src/mkds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mkds_pkg
// Shared constants, types and helpers of the keypad debounce scanner.
// ----------------------------------------------------------------------------
package mkds_pkg;

  localparam int ROWS     = 4;
  localparam int COLS     = 4;
  localparam int NKEYS    = ROWS * COLS;
  localparam int KEY_BITS = 16;
  localparam int LANES    = (NKEYS >= KEY_BITS) ? KEY_BITS : NKEYS;
  localparam int KEY_W    = 4;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int MAP_W    = 64;
  localparam int CODE_W   = 8;
  localparam int IDX_W    = 8;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 8'd0;
  localparam logic [IDX_W-1:0] REG_MAP_PRESENT = 8'd1;
  localparam logic [IDX_W-1:0] REG_MAP_LOW     = 8'd2;
  localparam logic [IDX_W-1:0] REG_MAP_HIGH    = 8'd3;

  localparam logic EV_RELEASE = 1'b0;
  localparam logic EV_PRESS   = 1'b1;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ms;
    logic             keymap_present;
    logic [MAP_W-1:0] keymap_low;
    logic [MAP_W-1:0] keymap_high;
  } cfg_t;

  typedef struct packed {
    logic             any;
    logic             multi;
    logic [KEY_W-1:0] key;
  } scan_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        row;
    logic [1:0]        col;
    logic [KEY_W-1:0]  index;
    logic [CODE_W-1:0] code;
    logic              code_valid;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } push_t;

  function automatic logic [1:0] key_row(input logic [KEY_W-1:0] k);
    int unsigned q;
    q = 32'(k) / COLS;
    return q[1:0];
  endfunction

  function automatic logic [1:0] key_col(input logic [KEY_W-1:0] k);
    int unsigned r;
    r = 32'(k) % COLS;
    return r[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/mkds_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mkds_lane
// One key lane: qualifies the key's bit and offers its index when pressed.
// ----------------------------------------------------------------------------
module mkds_lane
  import mkds_pkg::*;
(
  input  wire logic             down,
  input  wire logic [KEY_W-1:0] lane_id,
  output logic                  hit,
  output logic [KEY_W-1:0]      hit_index
);

  assign hit       = down;
  assign hit_index = down ? lane_id : '0;

endmodule
`default_nettype wire

// ===== src/mkds_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mkds_merge
// Combine the lane results: any key, more than one key, and the key index.
// ----------------------------------------------------------------------------
module mkds_merge
  import mkds_pkg::*;
(
  input  wire logic [KEY_BITS-1:0]            hits,
  input  wire logic [KEY_BITS-1:0][KEY_W-1:0] hit_index,
  output scan_t                               scan
);

  logic [KEY_W-1:0] idx_or;

  always_comb begin
    idx_or = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      idx_or = idx_or | hit_index[i];
    end
  end

  // Index from the OR of lanes is exact only when a single lane hits.
  assign scan.any   = |hits;
  assign scan.multi = |(hits & (hits - 1'b1));
  assign scan.key   = idx_or;

endmodule
`default_nettype wire

// ===== src/mkds_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mkds_core
// Candidate and held-key tracking; builds up to two events per scan.
// ----------------------------------------------------------------------------
module mkds_core
  import mkds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire scan_t             scan,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire cfg_t              cfg,
  output push_t                  push
);

  logic              candidate_valid, candidate_valid_next;
  logic [KEY_W-1:0]  candidate_key, candidate_key_next;
  logic [TIME_W-1:0] candidate_since, candidate_since_next;
  logic              held_valid, held_valid_next;
  logic [KEY_W-1:0]  held_key, held_key_next;

  logic              changed, rel, press, held_after;
  logic [TIME_W-1:0] elapsed;

  function automatic event_t make_event(input logic kind, input logic [KEY_W-1:0] k,
                                        input cfg_t c);
    event_t e;
    logic [MAP_W-1:0] word;
    word         = k[KEY_W-1] ? c.keymap_high : c.keymap_low;
    e.kind       = kind;
    e.row        = key_row(k);
    e.col        = key_col(k);
    e.index      = k;
    e.code       = c.keymap_present ? word[k[2:0]*CODE_W +: CODE_W] : '0;
    e.code_valid = c.keymap_present;
    e.last       = 1'b0;
    return e;
  endfunction

  always_comb begin
    changed = (scan.any != candidate_valid) || (scan.any && (scan.key != candidate_key));
    rel     = changed && candidate_valid && held_valid && (held_key == candidate_key);
    held_after = held_valid && !rel;

    candidate_valid_next = changed ? scan.any : candidate_valid;
    candidate_key_next   = changed ? scan.key : candidate_key;
    candidate_since_next = (changed && scan.any) ? now_ms : candidate_since;

    elapsed = now_ms - candidate_since_next;
    press   = scan.any && !(held_after && (held_key == scan.key)) &&
              (elapsed >= TIME_W'(cfg.debounce_ms));

    held_valid_next = press ? 1'b1 : held_after;
    held_key_next   = press ? scan.key : held_key;

    // A scan with several keys down leaves everything as it was.
    if (scan.multi) begin
      rel                  = 1'b0;
      press                = 1'b0;
      candidate_valid_next = candidate_valid;
      candidate_key_next   = candidate_key;
      candidate_since_next = candidate_since;
      held_valid_next      = held_valid;
      held_key_next        = held_key;
    end

    push.count    = 2'(rel) + 2'(press);
    push.ev0      = rel ? make_event(EV_RELEASE, candidate_key, cfg)
                        : make_event(EV_PRESS, scan.key, cfg);
    push.ev0.last = !(rel && press);
    push.ev1      = make_event(EV_PRESS, scan.key, cfg);
    push.ev1.last = 1'b1;
    if (!accept) begin
      push.count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_valid <= 1'b0;
      candidate_key   <= '0;
      candidate_since <= '0;
      held_valid      <= 1'b0;
      held_key        <= '0;
    end else if (accept) begin
      candidate_valid <= candidate_valid_next;
      candidate_key   <= candidate_key_next;
      candidate_since <= candidate_since_next;
      held_valid      <= held_valid_next;
      held_key        <= held_key_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mkds_evq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mkds_evq
// Four-entry event queue; takes up to two events a cycle, gives one.
// ----------------------------------------------------------------------------
module mkds_evq
  import mkds_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire push_t  push,
  output logic        room,
  output logic        ev_valid,
  input  wire logic   ev_ready,
  output event_t      ev
);

  event_t     ent [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop        = ev_valid && ev_ready;
  assign ev_valid   = (count != 3'd0);
  assign ev         = ent[rptr];
  assign room       = (count <= 3'd2);
  assign count_next = count + 3'(push.count) - 3'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      ent[wptr] <= push.ev0;
    end
    if (push.count == 2'd2) begin
      ent[wptr + 2'd1] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push.count;
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/matrix_keypad_debounce_scanner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_scanner_top
// Debounced single-key scanner for a keypad matrix, one scan per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one full matrix scan per
//   request: key_down_bits and the millisecond time now_ms. Output channel
//   (out_valid/out_ready) carries press/release events, zero to two per
//   scan; last_event marks the final event of a scan.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata; unknown
//   indexes are dropped. The user must write only while idle; no check is done.
// Timing:
//   A scan is decoded by one lane per key and merged in the same cycle; its
//   events are registered into the event queue and reach out_valid behind any
//   earlier events. One scan per cycle is taken while the four-entry event
//   queue has room for two events; the sustained rate is one scan per cycle,
//   bounded by the output at one event per cycle while out_ready is high.
// Reset:
//   rst clears tracking state, the queue, and loads debounce_ms = 1 with
//   no keymap. A stalled receiver fills the queue; in_ready then drops until
//   space for two events is free again, and no event is lost.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_scanner_top
  import mkds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // scan requests
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KEY_BITS-1:0] key_down_bits,
  input  wire logic [TIME_W-1:0]   now_ms,
  // events
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     event_kind,
  output logic [1:0]               key_row,
  output logic [1:0]               key_col,
  output logic [KEY_W-1:0]         key_index,
  output logic [CODE_W-1:0]        keycode,
  output logic                     keycode_valid,
  output logic                     last_event,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [MAP_W-1:0]    cfg_wdata
);

  cfg_t   cfg;
  scan_t  scan;
  push_t  push;
  event_t ev;
  logic   accept;

  logic [KEY_BITS-1:0]            hits;
  logic [KEY_BITS-1:0][KEY_W-1:0] hit_index;

  // Hold configuration registers; ignore writes to indexes beyond the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= DEB_W'(1);
      cfg.keymap_present <= 1'b0;
      cfg.keymap_low     <= '0;
      cfg.keymap_high    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_wdata[DEB_W-1:0];
        REG_MAP_PRESENT: cfg.keymap_present <= cfg_wdata[0];
        REG_MAP_LOW:     cfg.keymap_low     <= cfg_wdata;
        REG_MAP_HIGH:    cfg.keymap_high    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One lane per matrix key; bits beyond the matrix never hit.
  for (genvar i = 0; i < KEY_BITS; i++) begin : g_lane
    if (i < LANES) begin : g_used
      mkds_lane u_lane (
        .down      (key_down_bits[i]),
        .lane_id   (KEY_W'(i)),
        .hit       (hits[i]),
        .hit_index (hit_index[i])
      );
    end else begin : g_unused
      assign hits[i]      = 1'b0;
      assign hit_index[i] = '0;
    end
  end

  mkds_merge u_merge (
    .hits      (hits),
    .hit_index (hit_index),
    .scan      (scan)
  );

  assign accept = in_valid && in_ready;

  mkds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .scan   (scan),
    .now_ms (now_ms),
    .cfg    (cfg),
    .push   (push)
  );

  mkds_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (in_ready),
    .ev_valid (out_valid),
    .ev_ready (out_ready),
    .ev       (ev)
  );

  assign event_kind    = ev.kind;
  assign key_row       = ev.row;
  assign key_col       = ev.col;
  assign key_index     = ev.index;
  assign keycode       = ev.code;
  assign keycode_valid = ev.code_valid;
  assign last_event    = ev.last;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced matrix keypad scanner. Scan requests
// are queued by a stimulus process and handed to a valid/ready driver. Every
// accepted scan goes through a debounce tracker kept inside the bench. The
// events that the tracker predicts are compared field by field with what the
// block emits. Idle gaps and back-pressure are random.
// ----------------------------------------------------------------------------
module tb;
  import mkds_pkg::*;

  // Cycles to let pass once nothing is outstanding.
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 18;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 8;
  localparam logic [KEY_BITS-1:0] KEY_MASK =
    (NKEYS >= KEY_BITS) ? '1 : KEY_BITS'((1 << NKEYS) - 1);

  typedef struct {
    logic [KEY_BITS-1:0] bits;
    logic [TIME_W-1:0]   stamp;
  } scan_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KEY_BITS-1:0] key_down_bits = '0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                event_kind;
  logic [1:0]          key_row;
  logic [1:0]          key_col;
  logic [KEY_W-1:0]    key_index;
  logic [CODE_W-1:0]   keycode;
  logic                keycode_valid;
  logic                last_event;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [MAP_W-1:0]    cfg_wdata = '0;

  matrix_keypad_debounce_scanner_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .key_down_bits (key_down_bits),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .key_row       (key_row),
    .key_col       (key_col),
    .key_index     (key_index),
    .keycode       (keycode),
    .keycode_valid (keycode_valid),
    .last_event    (last_event),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the configuration and of the debounce tracking state
  // --------------------------------------------------------------------------
  logic [DEB_W-1:0]  deb_ms;
  logic              map_on;
  logic [MAP_W-1:0]  map_lo;
  logic [MAP_W-1:0]  map_hi;

  logic              cand_valid;
  logic [KEY_W-1:0]  cand_key;
  logic [TIME_W-1:0] cand_since;
  logic              held_valid;
  logic [KEY_W-1:0]  held_key;

  scan_req_t   scan_requests[$];   // requests still to be offered
  event_t      pending_events[$];  // events predicted but not yet seen
  scan_req_t   next_req;
  event_t      head_event;

  logic        calm = 1'b0;        // set to suppress all random idling
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned useful_items = 0;

  int unsigned err_count = 0;
  int unsigned scans_taken = 0;
  int unsigned ignored_scans = 0;
  int unsigned double_scans = 0;
  int unsigned presses_seen = 0;
  int unsigned releases_seen = 0;
  int unsigned settings_count = 0;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic event_t make_event(input logic kind, input logic [KEY_W-1:0] k);
    event_t e;
    logic [MAP_W-1:0] word;
    word = k[3] ? map_hi : map_lo;
    e.kind       = kind;
    e.row        = 2'(32'(k) / COLS);
    e.col        = 2'(32'(k) % COLS);
    e.index      = k;
    e.code       = map_on ? word[8 * k[2:0] +: 8] : '0;
    e.code_valid = map_on;
    e.last       = 1'b0;
    return e;
  endfunction

  // Advance the debounce tracker by one accepted scan and queue its events.
  task automatic track_scan_events(input logic [KEY_BITS-1:0] raw,
                                   input logic [TIME_W-1:0] stamp);
    logic [KEY_BITS-1:0] bits;
    logic                have;
    logic [KEY_W-1:0]    k;
    event_t              evs[$];
    bits = raw & KEY_MASK;
    have = |bits;
    k    = '0;
    scans_taken++;
    // several keys down: drop the scan, leave the state alone
    if (have && ((bits & (bits - 1'b1)) != '0)) begin
      ignored_scans++;
      return;
    end
    for (int i = KEY_BITS - 1; i >= 0; i--)
      if (bits[i]) k = KEY_W'(i);
    if (have != cand_valid || (have && k != cand_key)) begin
      if (cand_valid && held_valid && held_key == cand_key) begin
        evs.insert(evs.size(), make_event(EV_RELEASE, held_key));
        held_valid = 1'b0;
      end
      cand_valid = have;
      cand_key   = k;
      if (have) cand_since = stamp;
    end
    if (have && !(held_valid && held_key == k) &&
        (stamp - cand_since) >= TIME_W'(deb_ms)) begin
      evs.insert(evs.size(), make_event(EV_PRESS, k));
      held_valid = 1'b1;
      held_key   = k;
    end
    if (evs.size() != 0) evs[$].last = 1'b1;
    if (evs.size() == 2) double_scans++;
    foreach (evs[j]) pending_events.insert(pending_events.size(), evs[j]);
  endtask

  // --------------------------------------------------------------------------
  // Driver: take the accepted request into the tracker, then offer the next
  // one. Valid is only raised from an empty slot or right after acceptance,
  // so a request stays stable until the block takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_scan_events(key_down_bits, now_ms);
      if (!in_valid || in_ready) begin
        if (scan_requests.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_req = scan_requests.pop_front();
          in_valid      <= 1'b1;
          key_down_bits <= next_req.bits;
          now_ms        <= next_req.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted event against the oldest prediction and
  // stall the output at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected event",
                      {event_kind, key_row, key_col, key_index, keycode,
                       keycode_valid, last_event}, '0);
      end else begin
        head_event = pending_events.pop_front();
        if (head_event.kind == EV_PRESS) presses_seen++;
        else releases_seen++;
        if (event_kind !== head_event.kind)
          flag_mismatch("event_kind", event_kind, head_event.kind);
        if (key_row !== head_event.row)
          flag_mismatch("key_row", key_row, head_event.row);
        if (key_col !== head_event.col)
          flag_mismatch("key_col", key_col, head_event.col);
        if (key_index !== head_event.index)
          flag_mismatch("key_index", key_index, head_event.index);
        if (keycode !== head_event.code)
          flag_mismatch("keycode", keycode, head_event.code);
        if (keycode_valid !== head_event.code_valid)
          flag_mismatch("keycode_valid", keycode_valid, head_event.code_valid);
        if (last_event !== head_event.last)
          flag_mismatch("last_event", last_event, head_event.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MAP_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE:    deb_ms = val[DEB_W-1:0];
      REG_MAP_PRESENT: map_on = val[0];
      REG_MAP_LOW:     map_lo = val;
      REG_MAP_HIGH:    map_hi = val;
      default: ;
    endcase
  endtask

  // Write the whole register set; now and then poke an unused index too.
  task automatic load_settings(input logic [DEB_W-1:0] deb, input logic on,
                               input logic [MAP_W-1:0] lo, input logic [MAP_W-1:0] hi);
    write_reg(REG_DEBOUNCE, {$urandom(), $urandom()} & ~64'(16'hFFFF) | 64'(deb));
    write_reg(REG_MAP_PRESENT, {$urandom(), $urandom()} & ~64'd1 | 64'(on));
    write_reg(REG_MAP_LOW, lo);
    write_reg(REG_MAP_HIGH, hi);
    if ($urandom_range(0, 1))
      write_reg(IDX_W'($urandom_range(REG_MAP_HIGH + 1, 255)), {$urandom(), $urandom()});
    settings_count++;
  endtask

  // Hold off until nothing is queued, offered or expected, then settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (scan_requests.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_scan(input logic [KEY_BITS-1:0] bits, input logic [TIME_W-1:0] dt);
    scan_req_t r;
    clock_ms += dt;
    r.bits  = bits;
    r.stamp = clock_ms;
    scan_requests.insert(scan_requests.size(), r);
    if ($countones(bits) <= 1) useful_items++;
  endtask

  task automatic scan_at(input logic [KEY_BITS-1:0] bits, input logic [TIME_W-1:0] stamp);
    clock_ms = stamp;
    add_scan(bits, '0);
  endtask

  // One keystroke: contact bounce, a hold that may or may not outlast the
  // debounce time, then a release, a roll-over or a direct move to a new key.
  task automatic add_keystroke(input int unsigned deb);
    logic [KEY_W-1:0] k;
    logic [KEY_BITS-1:0] kbit;
    int unsigned hold_step;
    k         = KEY_W'($urandom_range(0, NKEYS - 1));
    kbit      = KEY_BITS'(1) << k;
    hold_step = deb / 2 + 2;
    if ($urandom_range(0, 19) == 0)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, deb + 4);
    repeat ($urandom_range(0, 3))
      add_scan($urandom_range(0, 1) ? kbit : '0, $urandom_range(0, 3));
    repeat ($urandom_range(1, 5))
      add_scan(kbit, $urandom_range(0, hold_step));
    case ($urandom_range(0, 9))
      0, 1: ;
      2: add_scan(kbit | (KEY_BITS'(1) << $urandom_range(0, NKEYS - 1)), 1);
      default: repeat ($urandom_range(1, 3)) add_scan('0, $urandom_range(0, 3));
    endcase
  endtask

  // Noise and broken sequences: random patterns, time jumps, stray taps.
  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: add_scan(KEY_BITS'($urandom()), $urandom_range(0, 50));
      1: scan_at(KEY_BITS'(1) << $urandom_range(0, NKEYS - 1), $urandom());
      2: add_scan('0, $urandom());
      default: add_scan(KEY_BITS'(1) << $urandom_range(0, NKEYS - 1), $urandom_range(0, 2));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [DEB_W-1:0] deb;
    logic             on;
    logic [MAP_W-1:0] lo;
    logic [MAP_W-1:0] hi;

    // reset values of the block
    deb_ms = 16'd1;
    map_on = 1'b0;
    map_lo = '0;
    map_hi = '0;
    cand_valid = 1'b0;
    cand_key   = '0;
    cand_since = '0;
    held_valid = 1'b0;
    held_key   = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: debounce of one, no keymap.
    scan_at(16'h0000, 32'd0);
    scan_at(16'h0001, 32'd0);           // candidate appears, too early
    scan_at(16'h0001, 32'd1);           // press of the lowest key
    scan_at(16'h0001, 32'd2);           // still held, nothing new
    scan_at(16'h8000, 32'd2);           // release, new candidate
    scan_at(16'h8000, 32'd3);           // press of the highest key
    scan_at(16'h0003, 32'd4);           // two keys down: dropped
    scan_at(16'hFFFF, 32'd5);           // every key down: dropped
    scan_at(16'h0000, 32'hFFFF_FFFF);   // release at the top of time
    wait_idle();

    // Zero debounce with a keymap: a key switch gives release and press.
    load_settings(16'd0, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    scan_at(16'h0020, 32'd10);
    scan_at(16'h0200, 32'd11);
    scan_at(16'h0200, 32'd12);
    scan_at(16'h0000, 32'd13);
    scan_at(16'h0000, 32'd14);
    wait_idle();

    // Debounce measured across the wrap of the time counter.
    load_settings(16'd10, 1'b1, '1, {$urandom(), $urandom()});
    scan_at(16'h0008, 32'hFFFF_FFFA);
    scan_at(16'h0008, 32'd3);
    scan_at(16'h0008, 32'd4);
    scan_at(16'h0000, 32'd5);
    scan_at(16'h4000, 32'd6);
    scan_at(16'h0000, 32'd7);           // never reported, so no release
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      lo = {$urandom(), $urandom()};
      hi = {$urandom(), $urandom()};
      on = 1'b1;
      case (p)
        0: deb = 16'd1;
        1: begin deb = 16'd0; on = 1'b0; end
        2: begin deb = 16'hFFFF; lo = '1; hi = '0; end
        3: deb = DEB_W'($urandom_range(2, 40));
        4: begin deb = DEB_W'($urandom()); on = 1'b0; end
        5: begin deb = 16'd5; lo = '0; hi = '1; end
        6: deb = DEB_W'($urandom_range(0, 3));
        default: deb = DEB_W'($urandom_range(10, 200));
      endcase
      load_settings(deb, on, lo, hi);
      // one long stretch with no idling on either side
      calm = (p == 3);
      useful_items = 0;
      while (useful_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) add_keystroke(deb);
        else add_noise();
      end
      wait_idle();
      calm = 1'b0;
    end

    $display("Covered %0d scans (%0d dropped as multi-key) over %0d register settings;",
             scans_taken, ignored_scans, settings_count);
    $display("checked %0d presses and %0d releases, %0d scans giving two events.",
             presses_seen, releases_seen, double_scans);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
